// ===== hw/rtl/jpd_pkg.sv =====
`default_nettype none

package jpd_pkg;

	// Address width default for the store side
	localparam int JPD_ADDR_BITS = 48;

	// Result kinds
	typedef logic [2:0] kind_t;
	localparam kind_t K_WRITE = 3'd0;
	localparam kind_t K_PASS  = 3'd1;
	localparam kind_t K_FAIL  = 3'd2;
	localparam kind_t K_DONE  = 3'd3;
	localparam kind_t K_RANGE = 3'd4;
	localparam kind_t K_TRUNC = 3'd5;

	// Configuration register indexes
	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t CFG_MODE       = 3'd0;
	localparam cfg_index_t CFG_JOURNAL_SZ = 3'd1;
	localparam cfg_index_t CFG_STORE_SZ   = 3'd2;
	localparam cfg_index_t CFG_TIMESTAMP  = 3'd3;
	localparam cfg_index_t CFG_END_MARKER = 3'd4;

	// Journal layout
	localparam logic [31:0] MIN_JOURNAL_BYTES = 32'd24;
	localparam logic [31:0] CRC_POLY          = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT          = 32'hFFFFFFFF;

	typedef struct packed {
		logic        mode;
		logic [31:0] journal_size;
		logic [47:0] store_size;
		logic [63:0] timestamp;
		logic [63:0] end_marker;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [29:0] word_count;
		logic [31:0] low_half;
		logic [31:0] crc;
		logic [10:0] words_left;
		logic        finished;
	} dec_state_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [47:0] address;
		logic [31:0] data;
	} result_t;

	// CRC over one 32-bit word equals shifting (crc ^ word) through 32 zero bits,
	// which is linear: each set bit contributes one fixed column.
	typedef logic [31:0] crc_cols_t [32];

	function automatic crc_cols_t crc_make_cols();
		crc_cols_t   cols;
		logic [31:0] c;
		logic        b;
		for (int k = 0; k < 32; k++) begin
			c = 32'd1 << k;
			for (int i = 0; i < 32; i++) begin
				b = c[0];
				c = c >> 1;
				if (b) begin
					c = c ^ CRC_POLY;
				end
			end
			cols[k] = c;
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = crc_make_cols();

	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
		logic [31:0] x;
		logic [31:0] r;
		x = crc ^ w;
		r = '0;
		for (int k = 0; k < 32; k++) begin
			if (x[k]) begin
				r = r ^ CRC_COLS[k];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jpd_step.sv =====
`default_nettype none

module jpd_step #(
	parameter int ADDR_BITS = jpd_pkg::JPD_ADDR_BITS
) (
	input  wire  jpd_pkg::cfg_t       cfg,
	input  wire  jpd_pkg::dec_state_t cur,
	input  wire  logic [ADDR_BITS-1:0] patch_address,
	input  wire  logic [31:0]          word,
	input  wire  logic                 last,
	output jpd_pkg::dec_state_t        nxt,
	output logic [ADDR_BITS-1:0]       patch_address_next,
	output jpd_pkg::result_t           res
);
	import jpd_pkg::*;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_ONE    = 3'd1;
	localparam logic [2:0] PH_TWO    = 3'd2;
	localparam logic [2:0] PH_THREE  = 3'd3;
	localparam logic [2:0] PH_FOUR   = 3'd4;
	localparam logic [2:0] PH_FIVE   = 3'd5;

	localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

	logic [63:0] full;
	logic [31:0] size_off;
	logic [29:0] wc_dec;
	logic [29:0] wc_init;
	logic [63:0] pos;
	logic [63:0] len;
	logic [63:0] store_lim;
	logic [63:0] addr_ext;
	logic [10:0] wl_dec;
	logic [10:0] wl_init;
	logic        hit;
	kind_t       kind;

	// Shared decode terms
	always_comb begin
		full      = {word, cur.low_half};
		size_off  = cfg.journal_size - MIN_JOURNAL_BYTES;
		wc_init   = size_off[31:2];
		wc_dec    = cur.word_count - 30'd1;
		pos       = {8'd0, full[63:10], 2'b00};
		wl_init   = {1'b0, full[9:0]} + 11'd1;
		len       = {51'd0, wl_init, 2'b00};
		store_lim = {16'd0, cfg.store_size} & ADDR_MASK;
		wl_dec    = cur.words_left - 11'd1;
		addr_ext  = 64'(patch_address);
	end

	// Advance the journal state for one word
	always_comb begin
		nxt                = cur;
		patch_address_next = patch_address;
		hit                = 1'b0;
		kind               = K_WRITE;
		if (!cur.finished) begin
			if (!cfg.mode) begin
				unique case (cur.phase)
					PH_ONE: begin
						if (full != cfg.timestamp) begin
							hit  = 1'b1;
							kind = K_FAIL;
						end else begin
							nxt.word_count = wc_init;
							nxt.phase      = (wc_init != '0) ? PH_TWO : PH_THREE;
						end
					end
					PH_TWO: begin
						nxt.crc        = crc_word(cur.crc, word);
						nxt.word_count = wc_dec;
						if (wc_dec == '0) begin
							nxt.phase = PH_THREE;
						end
					end
					PH_THREE: begin
						nxt.low_half = word;
						nxt.phase    = PH_FOUR;
					end
					PH_FOUR: begin
						if (full != cfg.end_marker) begin
							hit  = 1'b1;
							kind = K_FAIL;
						end else begin
							nxt.phase = PH_FIVE;
						end
					end
					PH_FIVE: begin
						hit  = 1'b1;
						kind = (word == ~cur.crc) ? K_PASS : K_FAIL;
					end
					default: begin
						if (cfg.journal_size < MIN_JOURNAL_BYTES ||
						    cfg.journal_size[1:0] != 2'b00) begin
							hit  = 1'b1;
							kind = K_FAIL;
						end else begin
							nxt.crc      = CRC_INIT;
							nxt.low_half = word;
							nxt.phase    = PH_ONE;
						end
					end
				endcase
			end else begin
				unique case (cur.phase)
					PH_ONE: begin
						nxt.phase = PH_TWO;
					end
					PH_TWO: begin
						nxt.low_half = word;
						nxt.phase    = PH_THREE;
					end
					PH_THREE: begin
						if (full == cfg.end_marker) begin
							hit  = 1'b1;
							kind = K_DONE;
						end else if (pos + len > store_lim) begin
							hit  = 1'b1;
							kind = K_RANGE;
						end else begin
							patch_address_next = pos[ADDR_BITS-1:0];
							nxt.words_left     = wl_init;
							nxt.phase          = PH_FOUR;
						end
					end
					PH_FOUR: begin
						hit                = 1'b1;
						kind               = K_WRITE;
						patch_address_next = patch_address + ADDR_BITS'(4);
						nxt.words_left     = wl_dec;
						if (wl_dec == '0) begin
							nxt.phase = PH_TWO;
						end
					end
					default: begin
						nxt.phase = PH_ONE;
					end
				endcase
			end
			if (hit && kind != K_WRITE) begin
				nxt.finished = 1'b1;
			end
			// Stream ended before a final report
			if (last && (!hit || kind == K_WRITE)) begin
				hit  = 1'b1;
				kind = cfg.mode ? K_TRUNC : K_FAIL;
			end
		end

		// Return to the start of the journal after the final word
		if (last) begin
			nxt.phase          = PH_START;
			nxt.word_count     = '0;
			nxt.low_half       = '0;
			nxt.crc            = CRC_INIT;
			nxt.words_left     = '0;
			nxt.finished       = 1'b0;
			patch_address_next = '0;
		end

		res.valid   = hit;
		res.kind    = kind;
		res.address = (kind == K_WRITE) ? addr_ext[47:0] : 48'd0;
		res.data    = (kind == K_WRITE) ? word : 32'd0;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/journal_patch_decoder.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    journal_word[31:0], last_word
// out       output     out_valid / out_ready  kind[2:0], write_address[47:0], write_data[31:0]
// cfg       input      cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[63:0]
//
// One journal word per cycle while the output is not stalled: a word sits in the
// input register, the decode and the CRC update run combinationally, and the result
// lands in the output register; words that cause no result retire without it. A
// stalled output holds the input register and then in_ready.
// Reset clears configuration and decoder state; cfg_ready is always high.

module journal_patch_decoder #(
	parameter int ADDR_BITS = jpd_pkg::JPD_ADDR_BITS
) (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	input  wire  logic                in_valid,
	output logic                      in_ready,
	input  wire  logic [31:0]         journal_word,
	input  wire  logic                last_word,
	output logic                      out_valid,
	input  wire  logic                out_ready,
	output jpd_pkg::kind_t            kind,
	output logic [47:0]               write_address,
	output logic [31:0]               write_data,
	input  wire  logic                cfg_valid,
	output logic                      cfg_ready,
	input  wire  jpd_pkg::cfg_index_t cfg_index,
	input  wire  logic [63:0]         cfg_data
);
	import jpd_pkg::*;

	cfg_t                 cfg_q;
	dec_state_t           state_q;
	dec_state_t           state_next;
	logic [ADDR_BITS-1:0] patch_address_q;
	logic [ADDR_BITS-1:0] patch_address_next;
	result_t              res;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        last_s1;
	logic        valid_s2;
	kind_t       kind_s2;
	logic [47:0] address_s2;
	logic [31:0] data_s2;
	logic        advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE:       cfg_q.mode         <= cfg_data[0];
				CFG_JOURNAL_SZ: cfg_q.journal_size <= cfg_data[31:0];
				CFG_STORE_SZ:   cfg_q.store_size   <= cfg_data[47:0];
				CFG_TIMESTAMP:  cfg_q.timestamp    <= cfg_data;
				CFG_END_MARKER: cfg_q.end_marker   <= cfg_data;
				default: ;
			endcase
		end
	end

	jpd_step #(
		.ADDR_BITS(ADDR_BITS)
	) u_step (
		.cfg                (cfg_q),
		.cur                (state_q),
		.patch_address      (patch_address_q),
		.word               (word_s1),
		.last               (last_s1),
		.nxt                (state_next),
		.patch_address_next (patch_address_next),
		.res                (res)
	);

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= journal_word;
			last_s1 <= last_word;
		end
	end

	// Advance decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= '{phase: 3'd0, word_count: '0, low_half: '0, crc: CRC_INIT,
			                     words_left: '0, finished: 1'b0};
			patch_address_q <= '0;
		end else if (advance) begin
			state_q         <= state_next;
			patch_address_q <= patch_address_next;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_s2    <= res.kind;
			address_s2 <= res.address;
			data_s2    <= res.data;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = kind_s2;
	assign write_address = address_s2;
	assign write_data    = data_s2;

endmodule

`default_nettype wire
